### rtl/avp_stream_deframer_macros.svh
// assertion macros for the attribute record deframer
// used by the rtl modules that carry concurrent checks; needs clk and rst_n in scope
`ifndef AVP_STREAM_DEFRAMER_MACROS_SVH
`define AVP_STREAM_DEFRAMER_MACROS_SVH

// property checked at every rising clock edge outside reset
`define AVP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every rising clock edge, reset included
`define AVP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/avp_pkg.sv
// shared types and constants of the attribute record deframer
// no dependencies; used by avp_parse_core and avp_stream_deframer
package avp_pkg;

  // input word: one packet byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_last;
  } in_word_t;

  // result word: payload byte or end-of-packet status
  typedef struct packed {
    logic       is_status;
    logic [7:0] payload_byte;
    logic       payload_end;
    logic [2:0] status;
  } out_word_t;

  // results that one input word gives, from the parser to the output queue
  typedef struct packed {
    logic      pay_valid;
    out_word_t pay_word;
    logic      stat_valid;
    out_word_t stat_word;
  } res_t;

  // status codes
  localparam logic [2:0] ST_OK_FOUND   = 3'd0;
  localparam logic [2:0] ST_OK_NONE    = 3'd1;
  localparam logic [2:0] ST_SHORT_HDR  = 3'd2;
  localparam logic [2:0] ST_SHORT_DATA = 3'd3;
  localparam logic [2:0] ST_MANDATORY  = 3'd4;
  localparam logic [2:0] ST_BAD_LEN    = 3'd5;
  localparam logic [2:0] ST_NO_ERROR   = 3'd0;

  // record header layout
  localparam logic [23:0] HDR_LEN_MIN   = 24'd8;
  localparam int          MANDATORY_BIT = 6;
  localparam logic [2:0]  HDR_LAST_IDX  = 3'd7;

  // wanted code after reset
  localparam logic [31:0] WANTED_CODE_RST = 32'd79;

endpackage

### rtl/avp_parse_core.sv
// record parser: header collection, data/pad counting, error tracking
// depends on avp_pkg and avp_stream_deframer_macros.svh
`include "avp_stream_deframer_macros.svh"

module avp_parse_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  avp_pkg::in_word_t in_word,
  input  logic [31:0]      wanted_code,
  output avp_pkg::res_t    res
);

  typedef enum logic [1:0] {
    SEC_HDR  = 2'd0,
    SEC_DATA = 2'd1,
    SEC_PAD  = 2'd2,
    SEC_SKIP = 2'd3
  } section_t;

  section_t    section_r, section_nxt;
  logic [2:0]  hcnt_r, hcnt_nxt;
  logic [55:0] hshift_r, hshift_nxt;
  logic [23:0] dleft_r, dleft_nxt;
  logic [1:0]  pad_r, pad_nxt;
  logic        found_r, found_nxt;
  logic        fwd_r, fwd_nxt;
  logic        rej_r, rej_nxt;
  logic [2:0]  err_r, err_nxt;

  logic [63:0] hdr;
  logic [31:0] hdr_code;
  logic [7:0]  hdr_flags;
  logic [23:0] hdr_len;
  logic [23:0] dl_dec;
  logic        fin_data;
  logic        fin_rej;
  logic [1:0]  fin_pad;
  logic [2:0]  st;
  logic        pkt_idle;

  assign hdr       = {hshift_r, in_word.data_byte};
  assign hdr_code  = hdr[63:32];
  assign hdr_flags = hdr[31:24];
  assign hdr_len   = hdr[23:0];
  assign dl_dec    = dleft_r - 24'd1;

  // next state and results for the current word
  always_comb begin
    section_nxt = section_r;
    hcnt_nxt    = hcnt_r;
    hshift_nxt  = hshift_r;
    dleft_nxt   = dleft_r;
    pad_nxt     = pad_r;
    found_nxt   = found_r;
    fwd_nxt     = fwd_r;
    rej_nxt     = rej_r;
    err_nxt     = err_r;
    fin_data    = 1'b0;
    fin_rej     = rej_r;
    fin_pad     = pad_r;
    st          = avp_pkg::ST_OK_NONE;
    res         = '0;

    unique case (section_r)
      SEC_HDR: begin
        hshift_nxt = hdr[55:0];
        hcnt_nxt   = hcnt_r + 3'd1;
        if (hcnt_r == avp_pkg::HDR_LAST_IDX) begin
          hcnt_nxt   = 3'd0;
          hshift_nxt = '0;
          if (hdr_len < avp_pkg::HDR_LEN_MIN) begin
            // bad length: skip rest of packet
            if (err_r == avp_pkg::ST_NO_ERROR) begin
              err_nxt = avp_pkg::ST_BAD_LEN;
            end
            section_nxt = SEC_SKIP;
            fwd_nxt     = 1'b0;
          end else begin
            dleft_nxt = hdr_len - avp_pkg::HDR_LEN_MIN;
            pad_nxt   = 2'd0 - hdr_len[1:0];
            fin_pad   = 2'd0 - hdr_len[1:0];
            if (hdr_code == wanted_code && !found_r) begin
              found_nxt = 1'b1;
              fwd_nxt   = 1'b1;
            end else if (hdr_flags[avp_pkg::MANDATORY_BIT]) begin
              rej_nxt = 1'b1;
              fin_rej = 1'b1;
            end
            if (hdr_len == avp_pkg::HDR_LEN_MIN) begin
              fin_data = 1'b1;
            end else begin
              section_nxt = SEC_DATA;
            end
          end
        end
      end
      SEC_DATA: begin
        dleft_nxt = dl_dec;
        if (fwd_r) begin
          res.pay_valid            = 1'b1;
          res.pay_word.is_status   = 1'b0;
          res.pay_word.payload_byte = in_word.data_byte;
          res.pay_word.payload_end = (dl_dec == 24'd0);
          res.pay_word.status      = avp_pkg::ST_NO_ERROR;
        end
        if (dl_dec == 24'd0) begin
          fin_data = 1'b1;
        end
      end
      SEC_PAD: begin
        pad_nxt = pad_r - 2'd1;
        if (pad_r == 2'd1) begin
          section_nxt = SEC_HDR;
        end
      end
      SEC_SKIP: begin
      end
      default: begin
      end
    endcase

    // data part complete: mandatory reject or move on to pad/header
    if (fin_data) begin
      fwd_nxt = 1'b0;
      if (fin_rej) begin
        rej_nxt = 1'b0;
        if (err_r == avp_pkg::ST_NO_ERROR) begin
          err_nxt = avp_pkg::ST_MANDATORY;
        end
        section_nxt = SEC_SKIP;
      end else begin
        section_nxt = (fin_pad != 2'd0) ? SEC_PAD : SEC_HDR;
      end
    end

    // end-of-packet status from the updated state
    if (err_nxt != avp_pkg::ST_NO_ERROR) begin
      st = err_nxt;
    end else if (section_nxt == SEC_HDR && hcnt_nxt != 3'd0) begin
      st = avp_pkg::ST_SHORT_HDR;
    end else if (section_nxt == SEC_DATA && dleft_nxt != 24'd0) begin
      st = avp_pkg::ST_SHORT_DATA;
    end else begin
      st = found_nxt ? avp_pkg::ST_OK_FOUND : avp_pkg::ST_OK_NONE;
    end
    res.stat_valid             = in_word.packet_last;
    res.stat_word.is_status    = 1'b1;
    res.stat_word.payload_byte = 8'd0;
    res.stat_word.payload_end  = 1'b0;
    res.stat_word.status       = st;

    // last word clears all per-packet state
    if (in_word.packet_last) begin
      section_nxt = SEC_HDR;
      hcnt_nxt    = 3'd0;
      hshift_nxt  = '0;
      dleft_nxt   = 24'd0;
      pad_nxt     = 2'd0;
      found_nxt   = 1'b0;
      fwd_nxt     = 1'b0;
      rej_nxt     = 1'b0;
      err_nxt     = avp_pkg::ST_NO_ERROR;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      section_r <= SEC_HDR;
      hcnt_r    <= 3'd0;
      dleft_r   <= 24'd0;
      pad_r     <= 2'd0;
      found_r   <= 1'b0;
      fwd_r     <= 1'b0;
      rej_r     <= 1'b0;
      err_r     <= avp_pkg::ST_NO_ERROR;
    end else if (step) begin
      section_r <= section_nxt;
      hcnt_r    <= hcnt_nxt;
      dleft_r   <= dleft_nxt;
      pad_r     <= pad_nxt;
      found_r   <= found_nxt;
      fwd_r     <= fwd_nxt;
      rej_r     <= rej_nxt;
      err_r     <= err_nxt;
    end
  end

  // header shift register
  always_ff @(posedge clk) begin
    if (step) begin
      hshift_r <= hshift_nxt;
    end
  end

  // parser back at the start of a packet
  assign pkt_idle = section_r == SEC_HDR && hcnt_r == 3'd0 && !found_r &&
                    err_r == avp_pkg::ST_NO_ERROR;

  // checks
  `AVP_ASSERT(a_fwd_found, fwd_r |-> found_r, "forwarding without a found record")
  `AVP_ASSERT(a_err_skip, (err_r != avp_pkg::ST_NO_ERROR) |-> section_r == SEC_SKIP, "error outside skip")
  `AVP_ASSERT(a_last_clear, (step && in_word.packet_last) |=> pkt_idle, "packet state not cleared")

endmodule

### rtl/avp_stream_deframer.sv
// top level of the attribute record deframer: input register, parser, output queue
// depends on avp_pkg, avp_parse_core and avp_stream_deframer_macros.svh
//
//   port group   dir  handshake          payload
//   in_*         in   in_valid/in_stall   avp_pkg::in_word_t
//   out_*        out  out_valid/out_stall avp_pkg::out_word_t
//   cfg_*        in   cfg_wr_en           32-bit wanted code
//
// One input word per cycle while in_stall is low; a word enters the input register, is
// parsed from there and its results land in a two-entry output queue, whose head is
// offered on out_word. A last word that also carries a payload byte gives two results
// and needs two free queue slots, which can stall the input.
// Reset is synchronous, active low, and clears control state only.
// out_stall backs up into the queue and then into in_stall.
`include "avp_stream_deframer_macros.svh"

module avp_stream_deframer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  avp_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output avp_pkg::out_word_t out_word,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data
);

  logic               in_valid_r;
  avp_pkg::in_word_t  in_word_r;
  logic [31:0]        wanted_code_r;
  avp_pkg::res_t      res;
  logic               consume;
  logic               pop;
  logic [1:0]         space;
  logic [1:0]         n_res;
  avp_pkg::out_word_t push0, q0_r, q0_nxt, q1_r, q1_nxt, e0;
  logic [1:0]         q_cnt_r, q_cnt_nxt, base_cnt;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_code_r <= avp_pkg::WANTED_CODE_RST;
    end else if (cfg_wr_en) begin
      wanted_code_r <= cfg_wr_data;
    end
  end

  // handshake and queue space
  assign pop      = out_valid & ~out_stall;
  assign n_res    = {1'b0, res.pay_valid} + {1'b0, res.stat_valid};
  assign space    = 2'd2 - q_cnt_r + {1'b0, pop};
  assign consume  = in_valid_r && (space >= n_res);
  assign in_stall = in_valid_r & ~consume;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_word_r <= in_word;
    end
  end

  // parser
  avp_parse_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (consume),
    .in_word     (in_word_r),
    .wanted_code (wanted_code_r),
    .res         (res)
  );

  // output queue: drop popped head, then append this word's results
  always_comb begin
    push0     = res.pay_valid ? res.pay_word : res.stat_word;
    base_cnt  = q_cnt_r - {1'b0, pop};
    e0        = pop ? q1_r : q0_r;
    q0_nxt    = e0;
    q1_nxt    = q1_r;
    q_cnt_nxt = base_cnt;
    if (consume) begin
      q_cnt_nxt = base_cnt + n_res;
      case (base_cnt)
        2'd0: begin
          q0_nxt = push0;
          q1_nxt = res.stat_word;
        end
        2'd1: begin
          q1_nxt = push0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= 2'd0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  assign out_valid = (q_cnt_r != 2'd0);
  assign out_word  = q0_r;

  // checks
  `AVP_ASSERT(a_q_bound, (q_cnt_r != 2'd3), "output queue overfilled")
  `AVP_ASSERT(a_in_hold, (in_valid_r && in_stall) |=> (in_valid_r && $stable(in_word_r)), "held word lost")
  `AVP_ASSERT(a_last_status, (consume && in_word_r.packet_last) |=> out_valid, "no status after last word")

endmodule
